// File: design/fel_pkg.sv
package fel_pkg;

    // Command codes carried on the cmd field
    localparam logic [3:0] OP_RECORD      = 4'd0;
    localparam logic [3:0] OP_READ_ALL    = 4'd1;
    localparam logic [3:0] OP_MATCH_SID   = 4'd2;
    localparam logic [3:0] OP_MATCH_PASID = 4'd3;
    localparam logic [3:0] OP_WINDOW      = 4'd4;
    localparam logic [3:0] OP_COUNT_FT    = 4'd5;
    localparam logic [3:0] OP_COUNT_AT    = 4'd6;
    localparam logic [3:0] OP_CLEAR       = 4'd7;
    localparam logic [3:0] OP_RESET_STATS = 4'd8;

    localparam logic [3:0] FT_TRANSLATION = 4'd0;
    localparam logic [3:0] FT_PERMISSION  = 4'd1;

    localparam logic [5:0] MAX_ENTRIES_RESET = 6'd32;

    // One stored fault record
    typedef struct packed {
        logic [31:0] stream_id;
        logic [19:0] pasid;
        logic [63:0] address;
        logic [1:0]  access_type;
        logic [3:0]  fault_type;
        logic [63:0] stamp;
    } t_rec;

    // Controller to datapath
    typedef struct packed {
        logic start;     // item accepted: trim, apply, latch keys
        logic rd;        // issue ring read at walk index
        logic count;     // add current entry to match count if it hits
        logic idx_inc;   // advance walk index
        logic idx_clr;   // restart walk
        logic emit_rec;  // load result register with current entry
        logic emit_sum;  // load result register with summary only
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_walk;   // incoming command walks the ring
        logic list_cmd;  // latched command returns records
        logic idx_end;   // walk index reached occupancy
        logic match;     // current read entry matches
        logic nh_zero;   // no matches counted
        logic last_hit;  // next emitted record is the final one
    } t_dp_sts;

endpackage

// File: design/fel_ram.sv
module fel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fel_dp.sv
module fel_dp #(
    parameter int DEPTH = 32,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [5:0]          i_cfg_data,
    input  fel_pkg::t_ctl_cmd   i_ctl,
    output fel_pkg::t_dp_sts    o_sts,
    input  logic [3:0]          i_cmd,
    input  logic [31:0]         i_stream_id,
    input  logic [19:0]         i_pasid,
    input  logic [63:0]         i_address,
    input  logic [3:0]          i_fault_type,
    input  logic [1:0]          i_access_type,
    input  logic [63:0]         i_time_now,
    input  logic [63:0]         i_time_window,
    output logic                o_has_record,
    output logic [31:0]         o_out_stream_id,
    output logic [19:0]         o_out_pasid,
    output logic [63:0]         o_out_address,
    output logic [3:0]          o_out_fault_type,
    output logic [1:0]          o_out_access_type,
    output logic [63:0]         o_out_stamp,
    output logic [5:0]          o_match_count,
    output logic [63:0]         o_total_count,
    output logic [63:0]         o_translation_count,
    output logic [63:0]         o_permission_count,
    output logic                o_last
);
    import fel_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (CW > 6) ? CW : 6;
    localparam int RW = $bits(t_rec);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = (CW + 1)'(a) + (CW + 1)'(b);
        if (sum >= DEPTH_W) begin
            f_wrap = AW'(sum - DEPTH_W);
        end else begin
            f_wrap = AW'(sum);
        end
    endfunction

    function automatic logic [5:0] f_cnt6(input logic [CW-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        f_cnt6 = w[5:0];
    endfunction

    // Control state
    logic [5:0]    r_max;
    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_occ, n_occ;
    logic [63:0]   r_total, n_total;
    logic [63:0]   r_trans, n_trans;
    logic [63:0]   r_perm, n_perm;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_nh;
    logic [CW-1:0] r_emitted;

    // Latched command and keys
    logic [3:0]  r_cmd;
    logic [31:0] r_key_sid;
    logic [19:0] r_key_pasid;
    logic [3:0]  r_key_ft;
    logic [1:0]  r_key_at;
    logic [63:0] r_now;
    logic [63:0] r_earliest;

    // Result register
    t_rec        r_out_rec;
    logic        r_out_has;
    logic [5:0]  r_out_cnt;
    logic [63:0] r_out_total;
    logic [63:0] r_out_trans;
    logic [63:0] r_out_perm;
    logic        r_out_last;

    logic [CW-1:0] lim;
    logic [AW-1:0] t_old, d_old, w_slot;
    logic [CW-1:0] t_occ, d_occ, w_occ;
    logic          rec_we;
    t_rec          wrec;
    t_rec          rrec;
    logic [RW-1:0] rdata;
    logic [AW-1:0] raddr;
    logic          hit;

    assign lim = (LW'(r_max) > DEPTH_L) ? DEPTH_C : CW'(r_max);

    always_comb begin
        // Drop oldest entries beyond the limit
        if (r_occ > lim) begin
            t_old = f_wrap(r_oldest, r_occ - lim);
            t_occ = lim;
        end else begin
            t_old = r_oldest;
            t_occ = r_occ;
        end
        // Make room in a full ring
        if (t_occ == DEPTH_C) begin
            d_old = f_wrap(t_old, CW'(1));
            d_occ = t_occ - CW'(1);
        end else begin
            d_old = t_old;
            d_occ = t_occ;
        end
        w_slot = f_wrap(d_old, d_occ);
        w_occ  = d_occ + CW'(1);
    end

    assign rec_we = i_ctl.start && (i_cmd == OP_RECORD);

    always_comb begin
        wrec.stream_id   = i_stream_id;
        wrec.pasid       = i_pasid;
        wrec.address     = i_address;
        wrec.access_type = i_access_type;
        wrec.fault_type  = i_fault_type;
        wrec.stamp       = i_time_now;
    end

    always_comb begin
        n_oldest = r_oldest;
        n_occ    = r_occ;
        n_total  = r_total;
        n_trans  = r_trans;
        n_perm   = r_perm;
        if (i_ctl.start) begin
            n_oldest = t_old;
            n_occ    = t_occ;
            case (i_cmd)
                OP_RECORD: begin
                    if (w_occ > lim) begin
                        n_oldest = f_wrap(d_old, CW'(1));
                        n_occ    = lim;
                    end else begin
                        n_oldest = d_old;
                        n_occ    = w_occ;
                    end
                    n_total = r_total + 64'd1;
                    if (i_fault_type == FT_TRANSLATION) begin
                        n_trans = r_trans + 64'd1;
                    end
                    if (i_fault_type == FT_PERMISSION) begin
                        n_perm = r_perm + 64'd1;
                    end
                end
                OP_CLEAR: begin
                    n_oldest = '0;
                    n_occ    = '0;
                end
                OP_RESET_STATS: begin
                    n_total = '0;
                    n_trans = '0;
                    n_perm  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign raddr = f_wrap(r_oldest, r_idx);

    fel_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (w_slot),
        .i_wdata (wrec),
        .i_re    (i_ctl.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rrec = t_rec'(rdata);

    always_comb begin
        case (r_cmd)
            OP_READ_ALL:    hit = 1'b1;
            OP_MATCH_SID:   hit = (rrec.stream_id == r_key_sid);
            OP_MATCH_PASID: hit = (rrec.pasid == r_key_pasid);
            OP_WINDOW:      hit = (rrec.stamp > r_earliest) && (rrec.stamp <= r_now);
            OP_COUNT_FT:    hit = (rrec.fault_type == r_key_ft);
            OP_COUNT_AT:    hit = (rrec.access_type == r_key_at);
            default:        hit = 1'b0;
        endcase
    end

    always_comb begin
        o_sts.in_walk  = (i_cmd inside {[OP_READ_ALL:OP_COUNT_AT]});
        o_sts.list_cmd = (r_cmd inside {[OP_READ_ALL:OP_WINDOW]});
        o_sts.idx_end  = (r_idx == r_occ);
        o_sts.match    = hit;
        o_sts.nh_zero  = (r_nh == '0);
        o_sts.last_hit = ((r_emitted + CW'(1)) == r_nh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_ENTRIES_RESET;
            r_oldest  <= '0;
            r_occ     <= '0;
            r_total   <= '0;
            r_trans   <= '0;
            r_perm    <= '0;
            r_idx     <= '0;
            r_nh      <= '0;
            r_emitted <= '0;
            r_cmd     <= OP_RECORD;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            r_oldest <= n_oldest;
            r_occ    <= n_occ;
            r_total  <= n_total;
            r_trans  <= n_trans;
            r_perm   <= n_perm;
            if (i_ctl.start || i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_ctl.start) begin
                r_nh      <= '0;
                r_emitted <= '0;
                r_cmd     <= i_cmd;
            end else begin
                if (i_ctl.count && hit) begin
                    r_nh <= r_nh + CW'(1);
                end
                if (i_ctl.emit_rec) begin
                    r_emitted <= r_emitted + CW'(1);
                end
            end
        end
    end

    // Keys and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_key_sid   <= i_stream_id;
            r_key_pasid <= i_pasid;
            r_key_ft    <= i_fault_type;
            r_key_at    <= i_access_type;
            r_now       <= i_time_now;
            r_earliest  <= (i_time_now > i_time_window) ? (i_time_now - i_time_window) : 64'd0;
        end
        if (i_ctl.emit_rec || i_ctl.emit_sum) begin
            r_out_total <= r_total;
            r_out_trans <= r_trans;
            r_out_perm  <= r_perm;
        end
        if (i_ctl.emit_rec) begin
            r_out_rec  <= rrec;
            r_out_has  <= 1'b1;
            r_out_cnt  <= f_cnt6(r_nh);
            r_out_last <= o_sts.last_hit;
        end else if (i_ctl.emit_sum) begin
            r_out_rec  <= '0;
            r_out_has  <= 1'b0;
            r_out_cnt  <= (r_cmd inside {[OP_READ_ALL:OP_COUNT_AT]}) ? f_cnt6(r_nh)
                                                                        : f_cnt6(r_occ);
            r_out_last <= 1'b1;
        end
    end

    assign o_has_record        = r_out_has;
    assign o_out_stream_id     = r_out_rec.stream_id;
    assign o_out_pasid         = r_out_rec.pasid;
    assign o_out_address       = r_out_rec.address;
    assign o_out_fault_type    = r_out_rec.fault_type;
    assign o_out_access_type   = r_out_rec.access_type;
    assign o_out_stamp         = r_out_rec.stamp;
    assign o_match_count       = r_out_cnt;
    assign o_total_count       = r_out_total;
    assign o_translation_count = r_out_trans;
    assign o_permission_count  = r_out_perm;
    assign o_last              = r_out_last;

endmodule

// File: design/fel_ctrl.sv
module fel_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  fel_pkg::t_dp_sts  i_sts,
    output fel_pkg::t_ctl_cmd o_ctl
);
    import fel_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ1,
        S_CHECK1,
        S_READ2,
        S_CHECK2,
        S_FINISH
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    logic     out_ready;
    t_ctl_cmd cmd;

    assign out_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = i_sts.in_walk ? S_READ1 : S_FINISH;
                end
            end
            S_READ1: begin
                if (i_sts.idx_end) begin
                    if (i_sts.list_cmd && !i_sts.nh_zero) begin
                        cmd.idx_clr = 1'b1;
                        n_state     = S_READ2;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_CHECK1;
                end
            end
            S_CHECK1: begin
                cmd.count   = 1'b1;
                cmd.idx_inc = 1'b1;
                n_state     = S_READ1;
            end
            S_READ2: begin
                cmd.rd  = 1'b1;
                n_state = S_CHECK2;
            end
            S_CHECK2: begin
                if (!i_sts.match) begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_READ2;
                end else if (out_ready) begin
                    cmd.emit_rec = 1'b1;
                    n_out_valid  = 1'b1;
                    if (i_sts.last_hit) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_READ2;
                    end
                end
            end
            S_FINISH: begin
                if (out_ready) begin
                    cmd.emit_sum = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl       = cmd;

    a_no_emit_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_rec || cmd.emit_sum) |-> !(r_out_valid && i_out_stall))
        else $error("result loaded while previous item still held");

    a_walk_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_sts.in_walk) |=> (r_state == S_READ1))
        else $error("query did not start ring walk");

    a_emit_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ2) |-> !i_sts.idx_end)
        else $error("record walk ran past occupancy");

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_rec && i_sts.last_hit) |=> (r_state == S_IDLE && r_out_valid))
        else $error("final record did not close the command");

endmodule

// File: design/fault_event_log_queue.sv
// Fault event log: keeps up to min(max_entries, DEPTH) fault records in a ring,
// oldest first, with wrapping 64-bit total, translation and permission counters.
// One item is worked on at a time. A record, clear, reset-stats or unused command
// goes to the finish state and loads its single result once the output can take
// it; the next item is taken in the cycle after that result is loaded. Queries
// walk the ring through its single read port with a registered read: a counting
// pass (a read and a check per entry, then the end test), then for list queries
// (read all, stream, pasid, time window) with a match a second pass of a read and
// a check per entry up to the last match, one result per match, each waiting on
// the output while it is stalled; other queries give one summary result. Every
// result carries the match count (or occupancy), so the count pass always runs
// first. The ring needs no clearing after reset; only live entries are ever read.
module fault_event_log_queue #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Limit register write
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    // Command item
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_cmd,
    input  logic [31:0] i_stream_id,
    input  logic [19:0] i_pasid,
    input  logic [63:0] i_address,
    input  logic [3:0]  i_fault_type,
    input  logic [1:0]  i_access_type,
    input  logic [63:0] i_time_now,
    input  logic [63:0] i_time_window,
    // Result item
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_record,
    output logic [31:0] o_out_stream_id,
    output logic [19:0] o_out_pasid,
    output logic [63:0] o_out_address,
    output logic [3:0]  o_out_fault_type,
    output logic [1:0]  o_out_access_type,
    output logic [63:0] o_out_stamp,
    output logic [5:0]  o_match_count,
    output logic [63:0] o_total_count,
    output logic [63:0] o_translation_count,
    output logic [63:0] o_permission_count,
    output logic        o_last
);
    import fel_pkg::*;

    // Controller sequences the walk; datapath owns the ring, counters and result register
    t_ctl_cmd ctl;
    t_dp_sts  sts;

    fel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    fel_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_ctl               (ctl),
        .o_sts               (sts),
        .i_cmd               (i_cmd),
        .i_stream_id         (i_stream_id),
        .i_pasid             (i_pasid),
        .i_address           (i_address),
        .i_fault_type        (i_fault_type),
        .i_access_type       (i_access_type),
        .i_time_now          (i_time_now),
        .i_time_window       (i_time_window),
        .o_has_record        (o_has_record),
        .o_out_stream_id     (o_out_stream_id),
        .o_out_pasid         (o_out_pasid),
        .o_out_address       (o_out_address),
        .o_out_fault_type    (o_out_fault_type),
        .o_out_access_type   (o_out_access_type),
        .o_out_stamp         (o_out_stamp),
        .o_match_count       (o_match_count),
        .o_total_count       (o_total_count),
        .o_translation_count (o_translation_count),
        .o_permission_count  (o_permission_count),
        .o_last              (o_last)
    );

endmodule
